// ===== design/bba_pkg.sv =====
// Package with the constants, types and helper functions of the bitmap block allocator.
package bba_pkg;

	localparam int NUM_BLOCKS   = 2048;
	localparam int RESERVED     = 10;
	localparam int RESERVED_EFF = (RESERVED > NUM_BLOCKS) ? NUM_BLOCKS : RESERVED;
	localparam int MAP_WORDS    = (NUM_BLOCKS + 31) / 32;
	localparam int WORD_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BLOCK_W      = 12;
	localparam int COUNT_W      = 13;
	localparam int BIT_W        = 5;

	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(NUM_BLOCKS - RESERVED_EFF);

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		STAT_OK           = 2'd0,
		STAT_NONE_FREE    = 2'd1,
		STAT_RANGE        = 2'd2,
		STAT_ALREADY_FREE = 2'd3
	} status_t;

	// Map word after reset: reserved blocks are marked used.
	function automatic logic [31:0] reset_word(input logic [WORD_W-1:0] w);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < 32; k++) begin
			r[k] = ((int'(w) * 32 + k) < RESERVED_EFF);
		end
		return r;
	endfunction

	// Bits of a map word that name real blocks.
	function automatic logic [31:0] limit_mask(input logic [WORD_W-1:0] w);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < 32; k++) begin
			r[k] = ((int'(w) * 32 + k) < NUM_BLOCKS);
		end
		return r;
	endfunction

	// Position of the lowest set bit.
	function automatic logic [BIT_W-1:0] lowest_set(input logic [31:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int k = 31; k >= 0; k--) begin
			if (v[k]) begin
				r = BIT_W'(k);
			end
		end
		return r;
	endfunction

endpackage

// ===== design/bitmap_block_allocator_core.sv =====
// Top level of the bitmap block allocator: used map memory, scan sequencer and result registers.
// A free command goes from IDLE through FREE_CHK to done; an out-of-range free finishes from IDLE.
// An allocate reads the used map one 32-bit word per cycle through one memory port, from word 0
// up to the word holding the lowest free block, or through all MAP_WORDS words when no block is free.
// One item at a time; done is high for one cycle and the receiver cannot stall.
// Reset is asynchronous; per-word valid bits make unwritten words read as reserved/free.
module bitmap_block_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [bba_pkg::BLOCK_W-1:0]   block_number,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [bba_pkg::BLOCK_W-1:0]   allocated_block,
	output logic [bba_pkg::COUNT_W-1:0]   free_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FREE_CHK
	} state_t;

	state_t state_q;

	logic [31:0] mem [bba_pkg::MAP_WORDS];
	logic [bba_pkg::MAP_WORDS-1:0] valid_q;

	logic [31:0]                   mem_rd_s1;
	logic                          vld_s1;
	logic [31:0]                   rst_word_s1;
	logic [31:0]                   mask_s1;

	logic [bba_pkg::WORD_W-1:0]    word_q;
	logic [bba_pkg::BIT_W-1:0]     bit_q;
	logic [bba_pkg::COUNT_W-1:0]   count_q;
	logic                          done_q;
	bba_pkg::status_t              status_q;
	logic [bba_pkg::BLOCK_W-1:0]   alloc_q;

	logic                          accept;
	logic                          in_range;
	logic                          rd_en;
	logic [bba_pkg::WORD_W-1:0]    rd_addr;
	logic                          wr_en;
	logic [31:0]                   wr_data;
	logic [31:0]                   cur_word;
	logic [31:0]                   free_bits;
	logic                          hit;
	logic [bba_pkg::BIT_W-1:0]     hit_bit;
	logic                          last_word;
	logic                          blk_used;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_range = (int'(block_number) < bba_pkg::NUM_BLOCKS);

	assign cur_word  = vld_s1 ? mem_rd_s1 : rst_word_s1;
	assign free_bits = ~cur_word & mask_s1;
	assign hit       = |free_bits;
	assign hit_bit   = bba_pkg::lowest_set(free_bits);
	assign last_word = (word_q == bba_pkg::WORD_W'(bba_pkg::MAP_WORDS - 1));
	assign blk_used  = cur_word[bit_q];

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = word_q + bba_pkg::WORD_W'(1);
		wr_en   = 1'b0;
		wr_data = cur_word;
		unique case (state_q)
			ST_IDLE: begin
				if (command == bba_pkg::CMD_FREE) begin
					rd_addr = bba_pkg::WORD_W'(block_number[bba_pkg::BLOCK_W-1:bba_pkg::BIT_W]);
					rd_en   = accept && in_range;
				end else begin
					rd_addr = '0;
					rd_en   = accept;
				end
			end
			ST_SCAN: begin
				rd_en   = !hit && !last_word;
				wr_en   = hit;
				wr_data = cur_word | (32'd1 << hit_bit);
			end
			ST_FREE_CHK: begin
				wr_en   = blk_used;
				wr_data = cur_word & ~(32'd1 << bit_q);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_s1   <= mem[rd_addr];
			rst_word_s1 <= bba_pkg::reset_word(rd_addr);
			mask_s1     <= bba_pkg::limit_mask(rd_addr);
		end
		if (wr_en) begin
			mem[word_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (rd_en) begin
				vld_s1 <= valid_q[rd_addr];
			end
			if (wr_en) begin
				valid_q[word_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			word_q   <= '0;
			bit_q    <= '0;
			count_q  <= bba_pkg::COUNT_RESET;
			done_q   <= 1'b0;
			status_q <= bba_pkg::STAT_OK;
			alloc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command == bba_pkg::CMD_FREE) begin
							word_q <= bba_pkg::WORD_W'(
								block_number[bba_pkg::BLOCK_W-1:bba_pkg::BIT_W]);
							bit_q  <= block_number[bba_pkg::BIT_W-1:0];
							if (in_range) begin
								state_q <= ST_FREE_CHK;
							end else begin
								done_q   <= 1'b1;
								status_q <= bba_pkg::STAT_RANGE;
								alloc_q  <= '0;
							end
						end else begin
							word_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						done_q   <= 1'b1;
						status_q <= bba_pkg::STAT_OK;
						alloc_q  <= bba_pkg::BLOCK_W'({word_q, hit_bit});
						count_q  <= count_q - bba_pkg::COUNT_W'(1);
						state_q  <= ST_IDLE;
					end else if (last_word) begin
						done_q   <= 1'b1;
						status_q <= bba_pkg::STAT_NONE_FREE;
						alloc_q  <= '0;
						state_q  <= ST_IDLE;
					end else begin
						word_q <= word_q + bba_pkg::WORD_W'(1);
					end
				end
				ST_FREE_CHK: begin
					done_q  <= 1'b1;
					alloc_q <= '0;
					state_q <= ST_IDLE;
					if (blk_used) begin
						status_q <= bba_pkg::STAT_OK;
						count_q  <= count_q + bba_pkg::COUNT_W'(1);
					end else begin
						status_q <= bba_pkg::STAT_ALREADY_FREE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign allocated_block = alloc_q;
	assign free_count      = count_q;

endmodule
